// ===== rtl/lbf_pkg.sv =====
// ----------------------------------------------------------------------------
// lbf_pkg
// Shared types and constants of the line or block byte framer.
// ----------------------------------------------------------------------------
`default_nettype none

package lbf_pkg;

  // Framing bytes
  localparam logic [7:0] NL_BYTE = 8'h0A;
  localparam logic [7:0] CR_BYTE = 8'h0D;

  // Record length counter
  localparam logic [15:0] LEN_MAX = 16'hFFFF;

  // Configuration register indexes
  localparam logic CFG_LINE_MODE  = 1'b0;
  localparam logic CFG_BLOCK_SIZE = 1'b1;

  // Result queue geometry (depth is a power of two)
  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

  // One result item
  typedef struct packed {
    logic [7:0] byte_out;
    logic       has_byte;
    logic       end_of_record;
  } result_t;

  // Results of one input item: count of valid slots, slot 0 first
  typedef struct packed {
    logic [1:0]         count;
    result_t [1:0]      res;
  } step_t;

endpackage : lbf_pkg

`default_nettype wire

// ===== rtl/lbf_core.sv =====
// ----------------------------------------------------------------------------
// lbf_core
// Framing state (held byte, record length) and the per-item step logic.
// ----------------------------------------------------------------------------
`default_nettype none

module lbf_core (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   line_mode_i,
  input  wire logic [15:0]            block_size_i,
  input  wire logic                   step_en_i,
  input  wire logic [7:0]             byte_in_i,
  output lbf_pkg::step_t              step_o
);

  logic [7:0]  held_q, held_d;
  logic        held_valid_q, held_valid_d;
  logic [15:0] len_q, len_d;
  logic [15:0] len_inc;
  logic        closing;

  // Work out the results of one item and the next state
  always_comb begin
    step_o       = '0;
    held_d       = held_q;
    held_valid_d = held_valid_q;
    len_d        = len_q;
    len_inc      = (len_q == lbf_pkg::LEN_MAX) ? len_q : len_q + 16'd1;
    closing      = 1'b0;
    if (!line_mode_i) begin
      // Block mode: flush any held byte, pass the new one on
      if (held_valid_q) begin
        step_o.res[0] = lbf_pkg::result_t'{byte_out: held_q, has_byte: 1'b1,
                                           end_of_record: 1'b0};
      end
      closing              = (len_inc >= block_size_i);
      step_o.res[held_valid_q] = lbf_pkg::result_t'{byte_out: byte_in_i,
                                                    has_byte: 1'b1,
                                                    end_of_record: closing};
      step_o.count = {1'b0, held_valid_q} + 2'd1;
      held_valid_d = 1'b0;
      held_d       = '0;
      len_d        = closing ? '0 : len_inc;
    end else if (byte_in_i == lbf_pkg::NL_BYTE) begin
      // Newline: close with the held byte, or with a bare marker
      if (held_valid_q && (held_q != lbf_pkg::CR_BYTE)) begin
        step_o.res[0] = lbf_pkg::result_t'{byte_out: held_q, has_byte: 1'b1,
                                           end_of_record: 1'b1};
      end else begin
        step_o.res[0] = lbf_pkg::result_t'{byte_out: 8'h00, has_byte: 1'b0,
                                           end_of_record: 1'b1};
      end
      step_o.count = 2'd1;
      held_valid_d = 1'b0;
      held_d       = '0;
      len_d        = '0;
    end else begin
      // Other byte in line mode: release the held byte, then hold or close
      if (held_valid_q) begin
        step_o.res[0] = lbf_pkg::result_t'{byte_out: held_q, has_byte: 1'b1,
                                           end_of_record: 1'b0};
      end
      closing = (block_size_i != 16'd0) && (len_inc >= block_size_i);
      if (closing) begin
        step_o.res[held_valid_q] = lbf_pkg::result_t'{byte_out: byte_in_i,
                                                      has_byte: 1'b1,
                                                      end_of_record: 1'b1};
        step_o.count = {1'b0, held_valid_q} + 2'd1;
        held_valid_d = 1'b0;
        held_d       = '0;
        len_d        = '0;
      end else begin
        step_o.count = {1'b0, held_valid_q};
        held_valid_d = 1'b1;
        held_d       = byte_in_i;
        len_d        = len_inc;
      end
    end
  end

  // Advance the framing state once per processed item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q       <= '0;
      held_valid_q <= 1'b0;
      len_q        <= '0;
    end else if (step_en_i) begin
      held_q       <= held_d;
      held_valid_q <= held_valid_d;
      len_q        <= len_d;
    end
  end

endmodule : lbf_core

`default_nettype wire

// ===== rtl/lbf_out_fifo.sv =====
// ----------------------------------------------------------------------------
// lbf_out_fifo
// Small result queue: takes up to two results a cycle, gives one a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module lbf_out_fifo (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          push_i,
  input  wire lbf_pkg::step_t                step_i,
  input  wire logic                          pop_i,
  output logic [lbf_pkg::CNT_W-1:0]          count_o,
  output lbf_pkg::result_t                   head_o
);

  lbf_pkg::result_t               mem_q [lbf_pkg::FIFO_DEPTH];
  logic [lbf_pkg::PTR_W-1:0]      wr_ptr_q, wr_ptr_d;
  logic [lbf_pkg::PTR_W-1:0]      rd_ptr_q, rd_ptr_d;
  logic [lbf_pkg::CNT_W-1:0]      count_q, count_d;
  logic [1:0]                     n_push;

  assign n_push  = push_i ? step_i.count : 2'd0;
  assign head_o  = mem_q[rd_ptr_q];
  assign count_o = count_q;

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q + lbf_pkg::PTR_W'(n_push);
    rd_ptr_d = rd_ptr_q + lbf_pkg::PTR_W'(pop_i);
    count_d  = count_q + lbf_pkg::CNT_W'(n_push) - lbf_pkg::CNT_W'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store the item's results in order
  always_ff @(posedge clk_i) begin
    if (n_push != 2'd0) begin
      mem_q[wr_ptr_q] <= step_i.res[0];
    end
    if (n_push == 2'd2) begin
      mem_q[wr_ptr_q + lbf_pkg::PTR_W'(1)] <= step_i.res[1];
    end
  end

endmodule : lbf_out_fifo

`default_nettype wire

// ===== rtl/line_or_block_byte_framer.sv =====
// Timing: the first result of an item reaches the outputs through the input register,
//   then the result queue, and can be taken while out_stall_i is low.
// Throughput: one item a cycle on the input while the queue has room for two results;
//   the output gives one result a cycle unless out_stall_i is high.
// Reset: asynchronous, active low; clears the queue, held byte and length, and sets
//   line_mode to 1 and block_size to 0.
// ----------------------------------------------------------------------------
// line_or_block_byte_framer
// Splits a byte stream into newline-terminated or fixed-length records.
// ----------------------------------------------------------------------------
`default_nettype none

module line_or_block_byte_framer (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Configuration write port
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_index_i,
  input  wire logic [15:0] cfg_data_i,
  // Input channel
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  byte_in_i,
  // Output channel
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [7:0]       byte_out_o,
  output logic             has_byte_o,
  output logic             end_of_record_o
);

  logic                          line_mode_q;
  logic [15:0]                   block_size_q;
  logic                          in_valid_q;
  logic [7:0]                    in_byte_q;
  logic                          proc;
  logic                          in_accept;
  logic                          out_pop;
  logic [lbf_pkg::CNT_W-1:0]     fifo_count;
  lbf_pkg::step_t                step;
  lbf_pkg::result_t              head;

  // Process the held item when the queue has room for two results
  assign proc      = in_valid_q &&
                     (fifo_count <= lbf_pkg::CNT_W'(lbf_pkg::FIFO_DEPTH - 2));
  assign in_stall_o = in_valid_q && !proc;
  assign in_accept = in_valid_i && !in_stall_o;
  assign out_valid_o = (fifo_count != '0);
  assign out_pop   = out_valid_o && !out_stall_i;

  assign byte_out_o      = head.byte_out;
  assign has_byte_o      = head.has_byte;
  assign end_of_record_o = head.end_of_record;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_mode_q  <= 1'b1;
      block_size_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        lbf_pkg::CFG_LINE_MODE:  line_mode_q  <= cfg_data_i[0];
        lbf_pkg::CFG_BLOCK_SIZE: block_size_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Input register: load on accept, drop once processed
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_accept) begin
      in_valid_q <= 1'b1;
    end else if (proc) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_byte_q <= byte_in_i;
    end
  end

  lbf_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .line_mode_i  (line_mode_q),
    .block_size_i (block_size_q),
    .step_en_i    (proc),
    .byte_in_i    (in_byte_q),
    .step_o       (step)
  );

  lbf_out_fifo u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (proc),
    .step_i  (step),
    .pop_i   (out_pop),
    .count_o (fifo_count),
    .head_o  (head)
  );

endmodule : line_or_block_byte_framer

`default_nettype wire

// ===== rtl/lbf_checker.sv =====
// ----------------------------------------------------------------------------
// lbf_checker
// Port-level checks of the byte framer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module lbf_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       out_valid_o,
  input wire logic       out_stall_i,
  input wire logic [7:0] byte_out_o,
  input wire logic       has_byte_o,
  input wire logic       end_of_record_o
);

  // No result shows while reset is applied
  assert property (@(posedge clk_i) !rst_ni |-> !out_valid_o)
    else $error("result shown during reset");

  // A stalled result holds until taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      out_valid_o && $stable(byte_out_o) && $stable(has_byte_o) &&
      $stable(end_of_record_o))
    else $error("stalled result changed");

  // A bare end marker always closes a record
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !has_byte_o |-> end_of_record_o)
    else $error("bare marker without end_of_record");

  // A bare end marker carries a zero byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !has_byte_o |-> (byte_out_o == 8'h00))
    else $error("bare marker with nonzero byte");

endmodule : lbf_checker

bind line_or_block_byte_framer lbf_checker u_lbf_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .byte_out_o      (byte_out_o),
  .has_byte_o      (has_byte_o),
  .end_of_record_o (end_of_record_o)
);

`default_nettype wire

// ===== sim/tb_line_or_block_byte_framer.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_line_or_block_byte_framer
// Self-checking bench for the line or block byte framer. A scoreboard
// class predicts the record bytes and end markers of every accepted item,
// and checks each delivered result against the oldest prediction. The run
// covers directed framing cases, a line closed under the top length limit,
// and random line and block traffic under a series of register
// settings, with random idling and back-pressure on both channels.
// ----------------------------------------------------------------------------

module tb_line_or_block_byte_framer;

  localparam int WATCHDOG_LIMIT = 1000;  // cycles without any transfer
  localparam int SETTLE_CYCLES  = 8;     // pipeline settle before a register write
  localparam int RX_HOLD_CYCLES = 150;   // long receiver hold-off
  localparam int PHASE_ITEMS    = 100;
  localparam int NUM_PHASES     = 14;

  // Predicts framer results from accepted bytes and checks delivered ones
  class framer_sb;
    bit               line_mode;
    logic [15:0]      block_size;
    logic [7:0]       held_byte;
    bit               held_valid;
    logic [15:0]      record_len;
    lbf_pkg::result_t pending_q[$];
    int               n_bytes;
    int               n_results;
    int               n_records;
    int               n_errors;

    function new();
      line_mode  = 1'b1;
      block_size = '0;
      held_byte  = '0;
      held_valid = 1'b0;
      record_len = '0;
      n_bytes    = 0;
      n_results  = 0;
      n_records  = 0;
      n_errors   = 0;
    endfunction

    function void set_reg(logic idx, logic [15:0] data);
      if (idx == lbf_pkg::CFG_LINE_MODE) line_mode = data[0];
      else block_size = data;
    endfunction

    function int pending();
      return pending_q.size();
    endfunction

    function void queue_result(logic [7:0] b, logic has, logic eor);
      lbf_pkg::result_t r;
      r.byte_out      = has ? b : 8'h00;
      r.has_byte      = has;
      r.end_of_record = eor;
      pending_q = {pending_q, r};
    endfunction

    function void count_len();
      if (record_len != lbf_pkg::LEN_MAX) record_len++;
    endfunction

    // Advance the framing state by one accepted item
    function void note_byte(logic [7:0] b);
      n_bytes++;
      if (!line_mode) begin
        // block mode: release any byte left from line mode, pass every byte on
        if (held_valid) queue_result(held_byte, 1'b1, 1'b0);
        held_valid = 1'b0;
        held_byte  = '0;
        count_len();
        if (record_len >= block_size) begin
          queue_result(b, 1'b1, 1'b1);
          record_len = '0;
        end else begin
          queue_result(b, 1'b1, 1'b0);
        end
      end else if (b == lbf_pkg::NL_BYTE) begin
        // newline closes the line; a held CR is dropped with it
        if (held_valid && held_byte != lbf_pkg::CR_BYTE)
          queue_result(held_byte, 1'b1, 1'b1);
        else queue_result(8'h00, 1'b0, 1'b1);
        held_valid = 1'b0;
        held_byte  = '0;
        record_len = '0;
      end else begin
        count_len();
        if (held_valid) queue_result(held_byte, 1'b1, 1'b0);
        if (block_size != 0 && record_len >= block_size) begin
          // over-long line: close on this byte, even a CR
          queue_result(b, 1'b1, 1'b1);
          held_valid = 1'b0;
          held_byte  = '0;
          record_len = '0;
        end else begin
          held_byte  = b;
          held_valid = 1'b1;
        end
      end
    endfunction

    // Compare one delivered result with the oldest prediction
    function void check_result(logic [7:0] bo, logic hb, logic eor);
      lbf_pkg::result_t want;
      n_results++;
      if (eor === 1'b1) n_records++;
      if (pending_q.size() == 0) begin
        $display("%0t ns: unexpected result: expected none, got %02h %0b %0b",
                 $time, bo, hb, eor);
        n_errors++;
      end else begin
        want = pending_q.pop_front();
        if (hb !== want.has_byte) begin
          $display("%0t ns: has_byte mismatch: expected %0b, got %0b",
                   $time, want.has_byte, hb);
          n_errors++;
        end
        // a bare end marker carries a zero byte
        if (bo !== want.byte_out) begin
          $display("%0t ns: byte_out mismatch: expected %02h, got %02h",
                   $time, want.byte_out, bo);
          n_errors++;
        end
        if (eor !== want.end_of_record) begin
          $display("%0t ns: end_of_record mismatch: expected %0b, got %0b",
                   $time, want.end_of_record, eor);
          n_errors++;
        end
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic        cfg_index_i;
  logic [15:0] cfg_data_i;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [7:0]  byte_in_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [7:0]  byte_out_o;
  logic        has_byte_o;
  logic        end_of_record_o;

  framer_sb sb;
  bit       burst_mode;    // both sides skip idling
  bit       rx_hold_req;   // ask the receiver for one long hold-off
  int       n_settings;
  int       idle_cycles;

  // Register settings of the random phases
  bit          phase_mode [NUM_PHASES] = '{1, 1, 1, 1, 0, 0, 0, 0, 1, 0, 1, 0, 1, 0};
  logic [15:0] phase_size [NUM_PHASES] = '{16'd0, 16'd1, 16'd4, 16'hFFFF, 16'd0, 16'd1,
                                           16'd5, 16'hFFFF, 16'd0, 16'd0, 16'd2, 16'd3,
                                           16'd0, 16'd0};

  line_or_block_byte_framer u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .byte_in_i      (byte_in_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .byte_out_o     (byte_out_o),
    .has_byte_o     (has_byte_o),
    .end_of_record_o(end_of_record_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Observe both channels
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) sb.note_byte(byte_in_i);
      if (out_valid_o && !out_stall_i)
        sb.check_result(byte_out_o, has_byte_o, end_of_record_o);
    end
  end

  // End the run when neither channel moves for too long
  initial begin
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
    $display("line_or_block_byte_framer regression: fail");
    $finish;
  end

  // Receiver: random stall before each result, one long hold-off on request
  initial begin
    int wait_n;
    out_stall_i <= 1'b0;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      if (rx_hold_req) begin
        out_stall_i <= 1'b1;
        repeat (RX_HOLD_CYCLES) @(posedge clk_i);
        rx_hold_req = 1'b0;
      end else begin
        wait_n = burst_mode ? 0 : $urandom_range(0, 3);
        if (wait_n > 0) begin
          out_stall_i <= 1'b1;
          repeat (wait_n) @(posedge clk_i);
        end
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // Offer one byte after a random gap and hold it until taken
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = burst_mode ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    byte_in_i  <= b;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  // Stop offering, wait for every predicted result, then let the pipeline settle
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Write both registers on back-to-back cycles; the block must be idle
  task automatic set_framing(input bit mode, input logic [15:0] size);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= lbf_pkg::CFG_LINE_MODE;
    cfg_data_i  <= {15'd0, mode};
    sb.set_reg(lbf_pkg::CFG_LINE_MODE, {15'd0, mode});
    @(posedge clk_i);
    cfg_index_i <= lbf_pkg::CFG_BLOCK_SIZE;
    cfg_data_i  <= size;
    sb.set_reg(lbf_pkg::CFG_BLOCK_SIZE, size);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    n_settings++;
  endtask

  // Any byte except newline
  function automatic logic [7:0] line_byte();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 7) == 0) b = lbf_pkg::CR_BYTE;
    if (b == lbf_pkg::NL_BYTE) b = 8'h41;
    return b;
  endfunction

  // Mostly well-formed lines with random content, some raw noise
  task automatic send_line_traffic(input int count);
    int sent;
    int len;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(0, 9) < 8) begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 10);
        for (int i = 0; i < len; i++) send_byte(line_byte());
        if ($urandom_range(0, 1)) begin
          send_byte(lbf_pkg::CR_BYTE);
          sent++;
        end
        send_byte(lbf_pkg::NL_BYTE);
        sent += len + 1;
      end else begin
        send_byte(8'($urandom_range(0, 255)));
        sent++;
      end
    end
  endtask

  // Raw bytes with framing characters mixed in
  task automatic send_block_traffic(input int count);
    logic [7:0] b;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 7))
        0:       b = lbf_pkg::NL_BYTE;
        1:       b = lbf_pkg::CR_BYTE;
        default: b = 8'($urandom_range(0, 255));
      endcase
      send_byte(b);
    end
  endtask

  initial begin
    logic [15:0] size;

    sb          = new();
    burst_mode  = 1'b0;
    rx_hold_req = 1'b0;
    n_settings  = 0;
    rst_ni      <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_index_i <= lbf_pkg::CFG_LINE_MODE;
    cfg_data_i  <= '0;
    in_valid_i  <= 1'b0;
    byte_in_i   <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Line mode from reset: plain line, empty line, CR before newline, byte extremes
    send_text("AB\n");
    send_byte(lbf_pkg::NL_BYTE);
    send_text("x\r\n");
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(lbf_pkg::NL_BYTE);
    drain();

    // Over-long lines close on the limit; a trailing CR is kept there
    set_framing(1'b1, 16'd3);
    send_text("abcd\n");
    send_text("ab\r");
    drain();

    // Switch to block mode with a byte held back
    set_framing(1'b1, 16'd0);
    send_byte("q");
    drain();
    set_framing(1'b0, 16'd0);
    send_byte("z");
    drain();

    // CR already passed on in block mode survives a newline in line mode
    set_framing(1'b0, 16'd2);
    send_byte(lbf_pkg::CR_BYTE);
    drain();
    set_framing(1'b1, 16'd2);
    send_byte(lbf_pkg::NL_BYTE);
    drain();

    // Lower the limit below the open length: the next byte closes
    set_framing(1'b1, 16'd0);
    send_text("hey");
    drain();
    set_framing(1'b1, 16'd2);
    send_byte("!");
    drain();

    // Close a line under the top limit
    set_framing(1'b1, 16'hFFFF);
    burst_mode = 1'b1;
    send_byte("s");
    send_byte(lbf_pkg::NL_BYTE);
    burst_mode = 1'b0;
    drain();

    // Random traffic under a series of settings; phases end mid-record at random
    for (int p = 0; p < NUM_PHASES; p++) begin
      size = phase_size[p];
      if (p == 8) size = 16'($urandom_range(0, 65535));
      else if (p == 9 || p == 13) size = 16'($urandom_range(1, 12));
      set_framing(phase_mode[p], size);
      burst_mode = (p == 6 || p == 12);
      if (p == 2) rx_hold_req = 1'b1;
      if (phase_mode[p]) send_line_traffic(PHASE_ITEMS);
      else send_block_traffic(PHASE_ITEMS);
      burst_mode = 1'b0;
      drain();
    end

    // Nothing may be left over or arrive late
    if (sb.pending() != 0) begin
      $display("%0t ns: %0d results never arrived", $time, sb.pending());
      sb.n_errors++;
    end

    $display("covered %0d bytes, %0d results in %0d records, %0d register settings",
             sb.n_bytes, sb.n_results, sb.n_records, n_settings);
    $display("line and block framing, mode and limit changes, long hold-off; %0d errors",
             sb.n_errors);
    if (sb.n_errors == 0) begin
      $display("line_or_block_byte_framer regression: pass");
    end else begin
      $display("line_or_block_byte_framer regression: fail");
    end
    $finish;
  end

endmodule
